### rtl/tcr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcr_pkg
// Shared types, constants and the 5x8 font table of the text column renderer.
// ---------------------------------------------------------------------------
package tcr_pkg;

   // field widths
   localparam int CODE_W      = 8;
   localparam int PAGE_W      = 3;
   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 7;
   localparam int POS_W       = 8;
   localparam int WIDTH_W     = 8;
   localparam int PCOUNT_W    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int GLYPH_IDX_W = 6;
   localparam int COL_W       = 3;

   // packed stream widths
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   // clip limit for the line width
   localparam int MAX_COLUMNS = 128;

   // font range and glyph shape
   localparam logic [CODE_W-1:0] CODE_FIRST  = 8'd32;
   localparam logic [CODE_W-1:0] CODE_LAST   = 8'd90;
   localparam int                GLYPH_COLS  = 5;
   localparam int                GLYPH_COUNT = 59;
   localparam logic [BYTE_W-1:0] BYTE_ONES   = 8'hFF;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT     = 2'd2;

   // reset values of the registers
   localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST = 8'd128;
   localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RST = 4'd8;

   // item kinds
   localparam logic CMD_CHAR     = 1'b0;
   localparam logic CMD_NEW_LINE = 1'b1;

   typedef struct packed {
      logic [WIDTH_W-1:0]  line_width;
      logic [PCOUNT_W-1:0] page_count;
      logic                invert;
   } cfg_type;

   // one glyph per entry, column 0 in the highest byte
   localparam logic [GLYPH_COLS*BYTE_W-1:0] FONT_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
      40'h6314081463, 40'h0304780403, 40'h6151494543
   };

   // column k of a glyph, zero for the spacer column
   function automatic logic [BYTE_W-1:0] glyph_column(
      input logic [GLYPH_IDX_W-1:0] idx,
      input logic [COL_W-1:0]       col
   );
      logic [GLYPH_COLS*BYTE_W-1:0] row;
      logic [BYTE_W-1:0]            result;
      row    = FONT_ROM[idx];
      result = '0;
      case (col)
         3'd0:    result = row[39:32];
         3'd1:    result = row[31:24];
         3'd2:    result = row[23:16];
         3'd3:    result = row[15:8];
         3'd4:    result = row[7:0];
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

### rtl/tcr_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcr_csr
// Configuration registers: line width, page count and invert.
// ---------------------------------------------------------------------------
module tcr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tcr_pkg::cfg_type               cfg
);
   import tcr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH: cfg_in.line_width = csr_wdata[WIDTH_W-1:0];
            CSR_PAGE_COUNT: cfg_in.page_count = csr_wdata[PCOUNT_W-1:0];
            CSR_INVERT:     cfg_in.invert     = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width <= LINE_WIDTH_RST;
         cfg_ff.page_count <= PAGE_COUNT_RST;
         cfg_ff.invert     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/tcr_column_gen.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcr_column_gen
// Holds one character, steps through up to six of its columns and feeds the result
// register; tracks the column position of the line.
// ---------------------------------------------------------------------------
module tcr_column_gen #(
   parameter int MAX_COLUMNS = tcr_pkg::MAX_COLUMNS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tcr_pkg::cfg_type            cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_command,
   input  logic [tcr_pkg::CODE_W-1:0]  req_char_code,
   input  logic [tcr_pkg::PAGE_W-1:0]  req_page,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tcr_pkg::BYTE_W-1:0]  rsp_column_byte,
   output logic [tcr_pkg::INDEX_W-1:0] rsp_column_index,
   output logic [tcr_pkg::PAGE_W-1:0]  rsp_page_out,
   output logic                        rsp_line_full,
   output logic                        rsp_last_of_run
);
   import tcr_pkg::*;

   localparam logic [COL_W-1:0]   SPACER_COL = COL_W'(GLYPH_COLS);
   localparam logic [WIDTH_W:0]   MAX_W      = (WIDTH_W+1)'(MAX_COLUMNS);

   // character in progress
   logic                   busy_ff, busy_in;
   logic [GLYPH_IDX_W-1:0] glyph_ff, glyph_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [POS_W-1:0]       pos_ff, pos_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic [INDEX_W-1:0]     out_index_ff;
   logic [PAGE_W-1:0]      out_page_ff;
   logic                   out_full_ff;
   logic                   out_last_ff;

   logic [WIDTH_W:0]       eff_width;
   logic [POS_W:0]         pos_plus;
   logic                   advance;
   logic                   col_last;
   logic                   done;
   logic                   req_fire;
   logic [POS_W-1:0]       pos_adv;
   logic [BYTE_W-1:0]      col_byte;
   logic                   code_ok;

   // line width clipped to the column limit
   assign eff_width = ({1'b0, cfg.line_width} > MAX_W) ? MAX_W : {1'b0, cfg.line_width};

   // column step and handshake control
   always_comb begin
      pos_plus   = {1'b0, pos_ff} + 1'b1;
      advance    = busy_ff && (!out_valid_ff || rsp_tready);
      col_last   = (col_ff == SPACER_COL) || (pos_plus == eff_width);
      done       = advance && col_last;
      req_tready = !busy_ff || done;
      req_fire   = req_tvalid && req_tready;
      pos_adv    = advance ? pos_plus[POS_W-1:0] : pos_ff;
      col_byte   = glyph_column(glyph_ff, col_ff) ^ (cfg.invert ? BYTE_ONES : '0);
      code_ok    = (req_char_code >= CODE_FIRST) && (req_char_code <= CODE_LAST);
   end

   // next state of the character in progress
   always_comb begin
      busy_in  = busy_ff && !done;
      pos_in   = pos_adv;
      col_in   = advance ? col_ff + 1'b1 : col_ff;
      glyph_in = glyph_ff;
      page_in  = page_ff;
      if (req_fire) begin
         if (req_command == CMD_NEW_LINE) begin
            pos_in = '0;
         end else if (({1'b0, req_page} < cfg.page_count) &&
                      ({1'b0, pos_adv} < eff_width)) begin
            busy_in  = 1'b1;
            col_in   = '0;
            glyph_in = code_ok ? GLYPH_IDX_W'(req_char_code - CODE_FIRST) : '0;
            page_in  = req_page;
         end
      end
   end

   // result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         col_ff       <= col_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      page_ff  <= page_in;
      if (advance) begin
         out_byte_ff  <= col_byte;
         out_index_ff <= pos_ff[INDEX_W-1:0];
         out_page_ff  <= page_ff;
         out_full_ff  <= (pos_plus == eff_width);
         out_last_ff  <= col_last;
      end
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_column_byte  = out_byte_ff;
   assign rsp_column_index = out_index_ff;
   assign rsp_page_out     = out_page_ff;
   assign rsp_line_full    = out_full_ff;
   assign rsp_last_of_run  = out_last_ff;

endmodule

### rtl/text_column_renderer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_column_renderer
// Renders characters into vertical column bytes of one 8-pixel page row.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one item per character: tuser is the command (0 draw a
//   character, 1 start a new line), tdata holds the code and the page.
//   rsp_* gives one item per display column: byte, column index and page in
//   tdata, line_full in tuser, tlast on the last column of a character.
//   csr_* writes line_width, page_count and invert; write only while idle.
// Flow:
//   a taken character is registered in the column stepper, then its first
//   column moves into the result register. A character gives up to six
//   columns, one per cycle unless rsp_tready stalls; the next character is
//   taken in the cycle its last column moves into the result register. The
//   stepper is the limit; new lines and characters giving no column leave it idle.
// Reset: clears the column position, the result register and the
//   registers to line_width 128, page_count 8, invert 0.
// Stall: while rsp_tready is low the result item holds and the column
//   stepper waits; req_tready drops until the character is done.
// ---------------------------------------------------------------------------
module text_column_renderer #(
   parameter int MAX_COLUMNS = tcr_pkg::MAX_COLUMNS
) (
   input  logic                               clock,
   input  logic                               reset,
   // csr
   input  logic                               csr_we,
   input  logic [tcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tcr_pkg::REQ_DATA_W-1:0]     req_tdata,  // char_code[7:0], page[10:8]
   input  logic                               req_tuser,  // command
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tcr_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // column_byte[7:0],
                                                          // column_index[14:8],
                                                          // page_out[17:15]
   output logic                               rsp_tuser,  // line_full
   output logic                               rsp_tlast   // last_of_run
);
   import tcr_pkg::*;

   cfg_type            cfg;
   logic [BYTE_W-1:0]  column_byte;
   logic [INDEX_W-1:0] column_index;
   logic [PAGE_W-1:0]  page_out;

   // configuration registers
   tcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // column stepper and result register
   tcr_column_gen #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_column_gen (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_command      (req_tuser),
      .req_char_code    (req_tdata[7:0]),
      .req_page         (req_tdata[10:8]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_column_byte  (column_byte),
      .rsp_column_index (column_index),
      .rsp_page_out     (page_out),
      .rsp_line_full    (rsp_tuser),
      .rsp_last_of_run  (rsp_tlast)
   );

   // pack result fields
   assign rsp_tdata = {6'b0, page_out, column_index, column_byte};

endmodule

### rtl/tcr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcr_checker
// Port-level checks of the text column renderer, bound to the top level.
// ---------------------------------------------------------------------------
module tcr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import tcr_pkg::*;

   // a stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // no result item right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // the last column of a line also ends the character
   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("line full without end of character");

   // a held request means a character is being drawn
   a_busy_emits: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> rsp_tvalid)
      else $error("request stalled with no column coming");

endmodule

bind text_column_renderer tcr_checker u_tcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### sim/text_column_renderer_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_column_renderer_test
// Self-checking bench for the text column renderer. Character and new-line
// items are driven on the request stream in random bursts. Every column item
// on the result stream is checked against columns predicted from a local
// copy of the font, the line position and the register settings. The run
// walks through directed corner cases, then random phases under several
// register settings, with random receiver stalls and one long hold-off.
// ---------------------------------------------------------------------------
module text_column_renderer_test;
   import tcr_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;
   localparam int SPACER_COL    = GLYPH_COLS;

   // register index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // 5x8 font, codes 32 to 90, column 0 in the highest byte
   localparam logic [GLYPH_COLS*BYTE_W-1:0] GLYPHS [59] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
      40'h6314081463, 40'h0304780403, 40'h6151494543
   };

   typedef struct {
      logic              cmd;
      logic [CODE_W-1:0] code;
      logic [PAGE_W-1:0] page;
   } text_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  pixels;
      logic [INDEX_W-1:0] index;
      logic [PAGE_W-1:0]  page;
      logic               full;
      logic               last;
   } column_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   // dut ports
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;  // char_code[7:0], page[10:8]
   logic                   req_tuser  = 1'b0; // command
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // column_byte[7:0], column_index[14:8],
                                             // page_out[17:15]
   logic                   rsp_tuser;        // line_full
   logic                   rsp_tlast;        // last_of_run

   // bench state
   text_item_type pending_items[$];
   column_type    expected_columns[$];
   cfg_type       shadow_cfg;
   logic [POS_W-1:0] line_position;
   logic          req_taken = 1'b0;
   int            items_queued = 0;
   int            items_accepted = 0;
   int            chars_accepted = 0;
   int            new_lines_accepted = 0;
   int            columns_checked = 0;
   int            fault_count = 0;
   int            settings_used = 0;
   int            hold_requests = 0;
   int            holds_served = 0;
   int            cycle_count = 0;

   text_column_renderer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLOCK_HALF clock = ~clock;

   // predicted columns of one accepted item, advances the line position
   task automatic render_columns(input logic cmd, input logic [CODE_W-1:0] code,
                                 input logic [PAGE_W-1:0] page);
      int unsigned              width;
      int unsigned              x;
      logic [CODE_W-1:0]        glyph_code;
      logic [GLYPH_COLS*BYTE_W-1:0] glyph;
      column_type               col;
      if (cmd == CMD_NEW_LINE) begin
         line_position = '0;
         return;
      end
      if ({1'b0, page} >= shadow_cfg.page_count)
         return;
      width = (shadow_cfg.line_width > MAX_COLUMNS) ? MAX_COLUMNS : shadow_cfg.line_width;
      glyph_code = (code < CODE_FIRST || code > CODE_LAST) ? CODE_FIRST : code;
      glyph = GLYPHS[glyph_code - CODE_FIRST];
      x = line_position;
      for (int k = 0; k <= SPACER_COL && x < width; k++) begin
         col.pixels = (k < SPACER_COL) ? glyph[(GLYPH_COLS-1-k)*BYTE_W +: BYTE_W] : '0;
         if (shadow_cfg.invert)
            col.pixels = ~col.pixels;
         col.index = x[INDEX_W-1:0];
         col.page  = page;
         col.full  = (x + 1 == width);
         col.last  = (k == SPACER_COL) || (x + 1 >= width);
         expected_columns.push_back(col);
         x++;
      end
      line_position = x[POS_W-1:0];
   endtask

   task automatic note_fault(input string what, input column_type exp_col,
                             input column_type got_col);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display({"%0t %s: exp byte %02h idx %0d page %0d full %0b last %0b, ",
                   "got byte %02h idx %0d page %0d full %0b last %0b"},
                  $realtime, what, exp_col.pixels, exp_col.index, exp_col.page, exp_col.full,
                  exp_col.last, got_col.pixels, got_col.index, got_col.page, got_col.full,
                  got_col.last);
   endtask

   // monitor: register shadow, prediction on accept, check on result
   always @(posedge clock) begin
      column_type got_col;
      column_type exp_col;
      req_taken = req_tvalid && req_tready && !reset;
      if (reset) begin
         shadow_cfg.line_width = LINE_WIDTH_RST;
         shadow_cfg.page_count = PAGE_COUNT_RST;
         shadow_cfg.invert     = 1'b0;
         line_position         = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LINE_WIDTH: shadow_cfg.line_width = csr_wdata[WIDTH_W-1:0];
               CSR_PAGE_COUNT: shadow_cfg.page_count = csr_wdata[PCOUNT_W-1:0];
               CSR_INVERT:     shadow_cfg.invert     = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_col = {rsp_tdata[7:0], rsp_tdata[14:8], rsp_tdata[17:15], rsp_tuser, rsp_tlast};
            columns_checked++;
            if (expected_columns.size() == 0) begin
               note_fault("unexpected column", '0, got_col);
            end else begin
               exp_col = expected_columns.pop_front();
               if (got_col !== exp_col)
                  note_fault("column mismatch", exp_col, got_col);
            end
         end
         if (req_taken) begin
            items_accepted++;
            if (req_tuser == CMD_NEW_LINE)
               new_lines_accepted++;
            else
               chars_accepted++;
            render_columns(req_tuser, req_tdata[7:0], req_tdata[10:8]);
         end
      end
   end

   // request driver: bursts of items with random gaps
   always @(negedge clock) begin
      text_item_type next_item;
      logic       offer;
      int         burst_left;
      int         gap_left;
      if (reset) begin
         burst_left = 1;
         gap_left   = 0;
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         offer = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_tdata <= {{(REQ_DATA_W-CODE_W-PAGE_W){1'b0}}, next_item.page, next_item.code};
            req_tuser <= next_item.cmd;
            offer = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end
         req_tvalid <= offer;
      end
   end

   // result receiver: stall modes that change now and then, plus long holds
   always @(negedge clock) begin
      rx_mode_type stall_mode;
      int       mode_left;
      int       hold_left;
      int       tick;
      logic     ready;
      if (reset) begin
         stall_mode = RX_OPEN;
         mode_left  = 0;
         hold_left  = 0;
         tick       = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
         end
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            case (stall_mode)
               RX_OPEN:   ready = 1'b1;
               RX_COIN:   ready = 1'($urandom_range(0, 1));
               RX_SPARSE: ready = ($urandom_range(0, 3) == 0);
               default:   ready = (tick % 3 == 0);
            endcase
         end
         tick++;
         rsp_tready <= ready;
      end
   end

   task automatic add_item(input logic cmd, input logic [CODE_W-1:0] code,
                           input logic [PAGE_W-1:0] page);
      text_item_type item;
      item.cmd  = cmd;
      item.code = code;
      item.page = page;
      pending_items.push_back(item);
      items_queued++;
   endtask

   // all items taken and all columns seen, then a short settle
   task automatic wait_idle();
      while (items_accepted != items_queued || expected_columns.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // unused upper bits of the narrow registers carry random junk
   task automatic set_registers(input logic [WIDTH_W-1:0] width,
                                input logic [PCOUNT_W-1:0] pages, input logic inv);
      logic [3:0] junk_hi;
      logic [6:0] junk_inv;
      junk_hi  = 4'($urandom);
      junk_inv = 7'($urandom);
      write_register(CSR_LINE_WIDTH, width);
      write_register(CSR_PAGE_COUNT, {junk_hi, pages});
      write_register(CSR_INVERT, {junk_inv, inv});
      settings_used++;
   endtask

   // mostly lines of printable characters ended by a new line, some noise
   task automatic random_phase(input logic [WIDTH_W-1:0] width,
                               input logic [PCOUNT_W-1:0] pages, input logic inv,
                               input int count, input bit long_hold);
      int unsigned eff_width;
      int unsigned line_cols;
      int          roll;
      logic [PAGE_W-1:0] page;
      set_registers(width, pages, inv);
      eff_width = (width > MAX_COLUMNS) ? MAX_COLUMNS : width;
      line_cols = 0;
      if ($urandom_range(0, 9) < 7)
         add_item(CMD_NEW_LINE, CODE_W'($urandom), PAGE_W'($urandom));
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (pages == 0)
            page = PAGE_W'($urandom);
         else if (pages >= 8)
            page = PAGE_W'($urandom_range(0, 7));
         else
            page = PAGE_W'($urandom_range(0, pages - 1));
         if (roll < 10) begin
            add_item(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 255)),
                     PAGE_W'($urandom_range(0, 7)));
         end else if (line_cols >= eff_width && eff_width != 0 && roll < 92) begin
            add_item(CMD_NEW_LINE, CODE_W'($urandom), PAGE_W'($urandom));
            line_cols = 0;
         end else begin
            add_item(CMD_CHAR, CODE_W'($urandom_range(CODE_FIRST, CODE_LAST)), page);
            line_cols += GLYPH_COLS + 1;
         end
      end
      if (long_hold)
         hold_requests++;
      wait_idle();
   endtask

   // stimulus sequence
   initial begin
      logic [WIDTH_W-1:0]  width;
      logic [PCOUNT_W-1:0] pages;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: new line, font ends, unsupported codes, page ends
      add_item(CMD_NEW_LINE, 8'hA5, 3'd5);
      add_item(CMD_CHAR, 8'd32, 3'd0);
      add_item(CMD_CHAR, 8'd33, 3'd0);
      add_item(CMD_CHAR, 8'd65, 3'd7);
      add_item(CMD_CHAR, 8'd90, 3'd3);
      add_item(CMD_CHAR, 8'd0, 3'd1);
      add_item(CMD_CHAR, 8'd31, 3'd2);
      add_item(CMD_CHAR, 8'd91, 3'd4);
      add_item(CMD_CHAR, 8'd255, 3'd5);
      add_item(CMD_CHAR, 8'd128, 3'd6);
      add_item(CMD_CHAR, 8'd127, 3'd7);
      add_item(CMD_CHAR, 8'd77, 3'd2);
      add_item(CMD_NEW_LINE, 8'hFF, 3'd7);
      add_item(CMD_CHAR, 8'd48, 3'd0);
      wait_idle();
      settings_used++;

      // one-column line, inverted: full line and page out of range
      set_registers(8'd1, 4'd1, 1'b1);
      add_item(CMD_CHAR, 8'd65, 3'd0);
      add_item(CMD_CHAR, 8'd66, 3'd0);
      add_item(CMD_NEW_LINE, 8'h00, 3'd0);
      add_item(CMD_CHAR, 8'd67, 3'd1);
      add_item(CMD_CHAR, 8'd67, 3'd0);
      wait_idle();

      // zero width gives no column; spare register index is ignored
      set_registers(8'd0, 4'd15, 1'b0);
      write_register(CSR_SPARE, CSR_DATA_W'($urandom));
      add_item(CMD_CHAR, 8'd88, 3'd7);
      add_item(CMD_NEW_LINE, 8'h5A, 3'd2);
      wait_idle();

      // no pages at all, width beyond the clip limit
      set_registers(8'd200, 4'd0, 1'b1);
      add_item(CMD_CHAR, 8'd70, 3'd0);
      wait_idle();

      // random phases, extremes first
      random_phase(8'd128, 4'd8, 1'b0, 36, 1'b0);
      random_phase(8'd255, 4'd15, 1'b1, 40, 1'b1);
      random_phase(8'd6, 4'd8, 1'b0, 30, 1'b0);
      random_phase(8'd7, 4'd3, 1'b1, 30, 1'b0);
      random_phase(8'd1, 4'd1, 1'b0, 24, 1'b0);
      random_phase(8'd127, 4'd2, 1'b0, 36, 1'b0);
      repeat (5) begin
         width = WIDTH_W'($urandom_range(2, 130));
         pages = PCOUNT_W'($urandom_range(1, 15));
         random_phase(width, pages, 1'($urandom_range(0, 1)), 34, 1'b0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_columns.size() != 0) begin
         $display("%0d expected columns never arrived", expected_columns.size());
         fault_count += expected_columns.size();
      end
      $display("run covered %0d characters and %0d new lines under %0d register settings",
               chars_accepted, new_lines_accepted, settings_used);
      $display("%0d columns compared, %0d faults", columns_checked, fault_count);
      if (fault_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
